FILE: design/assert_macros.svh
// Assertion helpers, used by pending_tag_table.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset
`define PTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included
`define PTH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PTH_ASSERT(lbl, prop, msg)
`define PTH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/pth_pkg.sv
package pth_pkg;

  // Outcome codes of a delete attempt
  localparam logic [2:0] ST_DEL_EVENT = 3'd0;
  localparam logic [2:0] ST_DEL_ALARM = 3'd1;
  localparam logic [2:0] ST_BAD_REF   = 3'd2;
  localparam logic [2:0] ST_ABSENT    = 3'd3;
  localparam logic [2:0] ST_KEPT      = 3'd4;
  localparam logic [2:0] ST_DUPLICATE = 3'd5;

  // Action codes
  localparam logic ACT_INGEST = 1'b0;
  localparam logic ACT_ACK    = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] tag_id;
    logic [15:0] ref_time;
    logic [15:0] now_time;
    logic [15:0] dup_seq;
    logic        is_alarm;
    logic        force_delete;
    logic        goes_global;
  } pth_in_t;

  typedef struct packed {
    logic [2:0] delete_status;
    logic       inserted;
    logic [3:0] alarm_count;
    logic [3:0] event_count;
  } pth_out_t;

  // One stored report
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] ref_time;
    logic [15:0] dup;
    logic        alarm;
  } pth_entry_t;

endpackage

FILE: design/pth_ram.sv
module pth_ram import pth_pkg::*; #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 12
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/pending_tag_table.sv
// Pending tag table: holds reports not yet confirmed by the master.
// Input channel: drive in_data and raise start; the beat is taken on a
// rising edge with start high and busy low. busy falls in the cycle that
// carries the result, so the next beat can be taken on the edge that takes
// the result; a new item is not taken before the last one's result.
// Result channel: out_valid is high for exactly one cycle with out_data
// (delete status, inserted flag, alarm and event counts after the item).
// The receiver cannot hold results off; it must take the beat as shown.
// Configuration: cfg_we with cfg_wdata writes is_master; write only while
// busy is low.
// Scan: entries live in a RAM with a registered read port and are
// scanned one slot a cycle from slot 0, stopping at the first slot that
// holds the tag or, if none does, at slot CAPACITY-1; the slot where the
// scan stops sets how long an item takes from accept to result.
// Reset (rst_n low, synchronous) clears the valid bits, both counts, the
// master flag and the control state; stored entries need no clearing.
`include "assert_macros.svh"

module pending_tag_table import pth_pkg::*; #(
  parameter int CAPACITY = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pth_in_t  in_data,
  output logic     out_valid,
  output pth_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  pth_in_t             item_r;
  logic                is_master_r;
  logic [CAPACITY-1:0] valid_r;
  logic [CW-1:0]       alarms_r;
  logic [CW-1:0]       events_r;
  logic [IW-1:0]       rd_idx_r;
  logic                rd_done_r;
  logic                cmp_vld_r;
  logic [IW-1:0]       cmp_idx_r;
  logic [2:0]          status_r;
  logic                out_valid_r;
  pth_out_t            out_r;

  logic                accept;
  logic                rd_en;
  pth_entry_t          rd_entry;
  logic [$bits(pth_entry_t)-1:0] rd_word;
  logic                hit;
  logic                scan_end;
  logic [2:0]          hit_status;
  logic [15:0]         eff_ref;
  logic                eff_force;
  logic [IW-1:0]       free_idx;
  logic                free_any;
  logic [CW:0]         held_sum;
  logic                do_insert;
  pth_entry_t          new_entry;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // entry store
  assign rd_en = (state_r == S_SCAN) && !rd_done_r;

  pth_ram #(
    .WIDTH ($bits(pth_entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (do_insert),
    .waddr (free_idx),
    .wdata (new_entry),
    .re    (rd_en),
    .raddr (rd_idx_r),
    .rdata (rd_word)
  );

  assign rd_entry = pth_entry_t'(rd_word);

  // ingest deletes with reference 0 and forces on alarms
  assign eff_ref   = (item_r.action == ACT_ACK) ? item_r.ref_time : 16'd0;
  assign eff_force = (item_r.action == ACT_ACK) ? item_r.force_delete : item_r.is_alarm;

  // compare the slot read last cycle
  assign hit      = cmp_vld_r && valid_r[cmp_idx_r] && (rd_entry.tag == item_r.tag_id);
  assign scan_end = cmp_vld_r && (hit || (cmp_idx_r == LAST));

  always_comb begin
    if (eff_ref != 16'd0 && rd_entry.ref_time != eff_ref) begin
      hit_status = ST_BAD_REF;
    end else if (eff_ref == 16'd0 && rd_entry.dup == item_r.dup_seq) begin
      hit_status = ST_DUPLICATE;
    end else if (!rd_entry.alarm) begin
      hit_status = ST_DEL_EVENT;
    end else if (!eff_force) begin
      hit_status = ST_KEPT;
    end else begin
      hit_status = ST_DEL_ALARM;
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign held_sum = {1'b0, alarms_r} + {1'b0, events_r};

  assign do_insert = (state_r == S_FIN) && (item_r.action == ACT_INGEST) &&
                     (status_r != ST_KEPT) && (status_r != ST_DUPLICATE) &&
                     !is_master_r && item_r.goes_global && item_r.is_alarm &&
                     (held_sum < (CW+1)'(CAPACITY)) && free_any;

  assign new_entry = '{tag: item_r.tag_id, ref_time: item_r.now_time,
                       dup: item_r.dup_seq, alarm: 1'b1};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_SCAN;
      S_SCAN: if (scan_end) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      is_master_r <= 1'b0;
      valid_r     <= '0;
      alarms_r    <= '0;
      events_r    <= '0;
      rd_done_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_FIN);
      if (cfg_we) begin
        is_master_r <= cfg_wdata;
      end

      // scan pointer
      if (accept) begin
        rd_done_r <= 1'b0;
        cmp_vld_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        if (!rd_done_r) begin
          rd_done_r <= (rd_idx_r == LAST);
        end
        cmp_vld_r <= rd_en && !scan_end;
      end

      // delete on a hit with a delete status
      if (state_r == S_SCAN && hit) begin
        if (hit_status == ST_DEL_EVENT) begin
          valid_r[cmp_idx_r] <= 1'b0;
          if (events_r != '0) events_r <= events_r - 1'b1;
        end else if (hit_status == ST_DEL_ALARM) begin
          valid_r[cmp_idx_r] <= 1'b0;
          if (alarms_r != '0) alarms_r <= alarms_r - 1'b1;
        end
      end

      // store a new alarm
      if (do_insert) begin
        valid_r[free_idx] <= 1'b1;
        alarms_r          <= alarms_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_data;
      rd_idx_r <= '0;
    end else if (rd_en && rd_idx_r != LAST) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    if (rd_en) begin
      cmp_idx_r <= rd_idx_r;
    end
    if (scan_end) begin
      status_r <= hit ? hit_status : ST_ABSENT;
    end
    if (state_r == S_FIN) begin
      out_r.delete_status <= status_r;
      out_r.inserted      <= do_insert;
      out_r.alarm_count   <= 4'(do_insert ? alarms_r + 1'b1 : alarms_r);
      out_r.event_count   <= 4'(events_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `PTH_ASSERT(a_cnt_match, $countones(valid_r) == int'(held_sum), "counts disagree with valid bits")
  `PTH_ASSERT(a_cnt_cap, held_sum <= (CW+1)'(CAPACITY), "table holds more than capacity")
  `PTH_ASSERT(a_out_after_fin, out_valid |-> $past(state_r == S_FIN), "result without finish step")
  `PTH_ASSERT(a_busy_after_accept, accept |=> busy, "accepted item did not raise busy")

endmodule

FILE: dv/pending_tag_table_tb.sv
module pending_tag_table_tb;
  import pth_pkg::*;

  localparam int CAPACITY        = 12;
  localparam int GAP_MAX         = 8;
  localparam int SETTLE_CYCLES   = CAPACITY + 8;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int PHASES          = 6;
  localparam int BEATS_PER_PHASE = 312;
  localparam int TAG_POOL        = 16;
  localparam int DUP_POOL        = 4;
  // is_master value per random phase, bit 0 first
  localparam logic [PHASES-1:0] MASTER_PLAN = 6'b010101;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  pth_in_t  in_data;
  logic     out_valid;
  pth_out_t out_data;
  logic     cfg_we;
  logic     cfg_wdata;

  pending_tag_table #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the table
  logic       master_flag;
  logic       slot_used [CAPACITY];
  pth_entry_t slot_ent  [CAPACITY];
  int         alarms_held;
  int         events_held;

  // Expected result beats, oldest first
  pth_out_t   pending_q [$];
  int         mismatches;
  int         beats_sent;
  int         idle_cycles;
  int         status_tally [8];
  int         stores;
  logic       idle_on;

  // Tag and duplicate-word pools, redrawn per phase so that hits are common
  logic [15:0] tag_pool [TAG_POOL];
  logic [15:0] dup_pool [DUP_POOL];

  typedef struct {
    pth_in_t  beat;
    logic     typed;
    pth_out_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  // Delete attempt: first slot holding the tag decides the outcome
  function automatic logic [2:0] remove_report(logic [15:0] tag, logic [15:0] reft,
                                               logic [15:0] dup, logic forced);
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot_used[i] && slot_ent[i].tag == tag) begin
        if (reft != 16'h0 && slot_ent[i].ref_time != reft) return ST_BAD_REF;
        if (reft == 16'h0 && slot_ent[i].dup == dup) return ST_DUPLICATE;
        if (!slot_ent[i].alarm) begin
          slot_used[i] = 1'b0;
          if (events_held > 0) events_held--;
          return ST_DEL_EVENT;
        end
        if (!forced) return ST_KEPT;
        slot_used[i] = 1'b0;
        if (alarms_held > 0) alarms_held--;
        return ST_DEL_ALARM;
      end
    end
    return ST_ABSENT;
  endfunction

  function automatic pth_out_t predict_beat(pth_in_t b);
    pth_out_t r;
    r = '0;
    if (b.action == ACT_ACK) begin
      r.delete_status = remove_report(b.tag_id, b.ref_time, b.dup_seq, b.force_delete);
    end else begin
      // ingest: delete uses reference 0, forced for alarms
      r.delete_status = remove_report(b.tag_id, 16'h0, b.dup_seq, b.is_alarm);
      if (r.delete_status != ST_KEPT && r.delete_status != ST_DUPLICATE && !master_flag &&
          b.goes_global && b.is_alarm && alarms_held + events_held < CAPACITY) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!slot_used[i]) begin
            slot_used[i]         = 1'b1;
            slot_ent[i].tag      = b.tag_id;
            slot_ent[i].ref_time = b.now_time;
            slot_ent[i].dup      = b.dup_seq;
            slot_ent[i].alarm    = 1'b1;
            alarms_held++;
            r.inserted = 1'b1;
            break;
          end
        end
      end
    end
    r.alarm_count = 4'(alarms_held);
    r.event_count = 4'(events_held);
    return r;
  endfunction

  function automatic pth_in_t mk_beat(logic act, logic [15:0] tag, logic [15:0] reft,
                                      logic [15:0] now, logic [15:0] dup, logic alarm,
                                      logic frc, logic glob);
    pth_in_t b;
    b.action       = act;
    b.tag_id       = tag;
    b.ref_time     = reft;
    b.now_time     = now;
    b.dup_seq      = dup;
    b.is_alarm     = alarm;
    b.force_delete = frc;
    b.goes_global  = glob;
    return b;
  endfunction

  function automatic pth_out_t mk_res(logic [2:0] st, logic ins, logic [3:0] alarms,
                                      logic [3:0] events);
    pth_out_t r;
    r.delete_status = st;
    r.inserted      = ins;
    r.alarm_count   = alarms;
    r.event_count   = events;
    return r;
  endfunction

  function automatic void add_row(pth_in_t b, logic typed, pth_out_t want);
    stim_row_t row;
    row.beat  = b;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void refresh_pools();
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = 16'($urandom);
    for (int i = 0; i < DUP_POOL; i++) dup_pool[i] = 16'($urandom);
  endfunction

  // Mostly well-formed traffic: acks aimed at held entries, ingests from a small pool
  function automatic pth_in_t random_beat();
    pth_in_t b;
    int      k;
    int      s;
    b = mk_beat(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 3) != 0));
    if ($urandom_range(0, 7) != 0) b.tag_id = tag_pool[$urandom_range(0, TAG_POOL - 1)];
    if ($urandom_range(0, 3) != 0) b.dup_seq = dup_pool[$urandom_range(0, DUP_POOL - 1)];
    if ($urandom_range(0, 9) < 3) b.ref_time = 16'h0;
    if (b.action == ACT_ACK && alarms_held + events_held > 0 && $urandom_range(0, 1)) begin
      s = -1;
      k = $urandom_range(0, CAPACITY - 1);
      for (int i = 0; i < CAPACITY; i++) begin
        if (s < 0 && slot_used[(k + i) % CAPACITY]) s = (k + i) % CAPACITY;
      end
      b.tag_id = slot_ent[s].tag;
      case ($urandom_range(0, 3))
        0, 1:    b.ref_time = slot_ent[s].ref_time;
        2:       b.ref_time = 16'h0;
        default: b.ref_time = 16'($urandom);
      endcase
    end
    return b;
  endfunction

  // One input beat: optional gap, then hold start until taken
  task automatic send_beat(pth_in_t b, logic typed, pth_out_t want);
    int       gap;
    pth_out_t p;
    if ($urandom_range(0, 49) == 0) idle_on = !idle_on;
    gap = idle_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    p = predict_beat(b);
    pending_q.push_back(typed ? want : p);
    beats_sent++;
    stores += p.inserted;
    status_tally[p.delete_status]++;
  endtask

  // Wait for the block to go quiet
  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_master(logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    master_flag = v;
    cfg_we <= 1'b0;
  endtask

  // Directed rows; typed results only where obvious
  function automatic void build_directed();
    add_row(mk_beat(ACT_ACK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0), 1,
            mk_res(ST_ABSENT, 0, 0, 0));
    add_row(mk_beat(ACT_INGEST, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1), 1,
            mk_res(ST_ABSENT, 1, 1, 0));
    add_row(mk_beat(ACT_INGEST, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 1, 0, 1), 1,
            mk_res(ST_DUPLICATE, 0, 1, 0));
    // event report meets a held alarm: unforced, so alarm kept
    add_row(mk_beat(ACT_INGEST, 16'hFFFF, 16'h0000, 16'h0002, 16'h0000, 0, 1, 1), 1,
            mk_res(ST_KEPT, 0, 1, 0));
    add_row(mk_beat(ACT_ACK, 16'hFFFF, 16'h1234, 16'h0000, 16'h0000, 0, 1, 0), 1,
            mk_res(ST_BAD_REF, 0, 1, 0));
    add_row(mk_beat(ACT_ACK, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1, 0, 1), 1,
            mk_res(ST_KEPT, 0, 1, 0));
    add_row(mk_beat(ACT_ACK, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 0, 1, 0), 1,
            mk_res(ST_DEL_ALARM, 0, 0, 0));
    // alarm that does not go global is not stored
    add_row(mk_beat(ACT_INGEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0), 1,
            mk_res(ST_ABSENT, 0, 0, 0));
    add_row(mk_beat(ACT_INGEST, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 1), 1,
            mk_res(ST_ABSENT, 1, 1, 0));
    // reference 0 skips the reference check
    add_row(mk_beat(ACT_ACK, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 0, 1, 0), 1,
            mk_res(ST_DEL_ALARM, 0, 0, 0));
    add_row(mk_beat(ACT_INGEST, 16'h0005, 16'h0000, 16'd100, 16'h0001, 1, 0, 1), 1,
            mk_res(ST_ABSENT, 1, 1, 0));
    // same tag again: forced delete, then restored with the new time
    add_row(mk_beat(ACT_INGEST, 16'h0005, 16'h0000, 16'd200, 16'h0002, 1, 0, 1), 1,
            mk_res(ST_DEL_ALARM, 1, 1, 0));
    add_row(mk_beat(ACT_ACK, 16'h0005, 16'h0000, 16'h0000, 16'h0002, 0, 1, 0), 1,
            mk_res(ST_DUPLICATE, 0, 1, 0));
    add_row(mk_beat(ACT_ACK, 16'h0005, 16'd100, 16'h0000, 16'h0000, 0, 1, 0), 1,
            mk_res(ST_BAD_REF, 0, 1, 0));
    // fill the table to capacity
    for (int t = 1; t < CAPACITY; t++) begin
      add_row(mk_beat(ACT_INGEST, 16'(16'h0100 + t), 16'h0000, 16'(t), 16'(t), 1, 0, 1), 0,
              '0);
    end
    add_row(mk_beat(ACT_INGEST, 16'h0777, 16'h0000, 16'h0033, 16'h0000, 1, 0, 1), 1,
            mk_res(ST_ABSENT, 0, 4'(CAPACITY), 0));
    // full table, but the delete frees a slot first
    add_row(mk_beat(ACT_INGEST, 16'h0105, 16'h0000, 16'h0044, 16'h0000, 1, 0, 1), 1,
            mk_res(ST_DEL_ALARM, 1, 4'(CAPACITY), 0));
  endfunction

  // Stimulus
  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_data     <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 1'b0;
    master_flag  = 1'b0;
    alarms_held  = 0;
    events_held  = 0;
    mismatches   = 0;
    beats_sent   = 0;
    stores       = 0;
    idle_on      = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_used[i] = 1'b0;
      slot_ent[i]  = '0;
    end
    for (int i = 0; i < 8; i++) status_tally[i] = 0;
    build_directed();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_master(MASTER_PLAN[ph]);
      refresh_pools();
      for (int n = 0; n < BEATS_PER_PHASE; n++) send_beat(random_beat(), 1'b0, '0);
    end

    drain();
    $display("Covered %0d beats over %0d is_master phases: %0d stores, %0d alarm deletes,",
             beats_sent, PHASES, stores, status_tally[ST_DEL_ALARM]);
    $display("  %0d bad refs, %0d absent, %0d kept alarms, %0d duplicates",
             status_tally[ST_BAD_REF], status_tally[ST_ABSENT], status_tally[ST_KEPT],
             status_tally[ST_DUPLICATE]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result beats against the oldest expectation
  always @(posedge clk) begin
    pth_out_t want;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending: %p", out_data);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (out_data.delete_status !== want.delete_status) begin
          $error("delete_status: expected %0d, got %0d", want.delete_status,
                 out_data.delete_status);
          mismatches++;
        end
        if (out_data.inserted !== want.inserted) begin
          $error("inserted: expected %0d, got %0d", want.inserted, out_data.inserted);
          mismatches++;
        end
        if (out_data.alarm_count !== want.alarm_count) begin
          $error("alarm_count: expected %0d, got %0d", want.alarm_count,
                 out_data.alarm_count);
          mismatches++;
        end
        if (out_data.event_count !== want.event_count) begin
          $error("event_count: expected %0d, got %0d", want.event_count,
                 out_data.event_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any beat moving
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
+incdir+design
design/pth_pkg.sv
design/pth_ram.sv
design/pending_tag_table.sv
dv/pending_tag_table_tb.sv
